[sv/onenc_pkg.sv]
// ----------------------------------------------------------------------------
// onenc_pkg
// Shared widths, constants and stage payload types of the octahedral normal
// encoder pipeline.
// ----------------------------------------------------------------------------
package onenc_pkg;

    localparam int IN_BITS  = 16;
    localparam int OUT_BITS = 16;

    // quotient fraction bits and quotient width (covers the value 1.0)
    localparam int QF = 16;
    localparam int QB = QF + 1;

    // l1 norm width, remainder / divisor width, pre-map value width
    localparam int L1W = IN_BITS + 1;
    localparam int RW  = L1W + 1;
    localparam int WW  = QB + 1;

    localparam int S_TDATA_W = ((3 * IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * OUT_BITS + 7) / 8) * 8;

    localparam logic [WW-1:0]       ONE_Q    = WW'(1) << QF;
    localparam logic [OUT_BITS-1:0] OUT_HALF = OUT_BITS'(1) << (OUT_BITS - 1);
    localparam logic [OUT_BITS-1:0] OUT_MAX  = {OUT_BITS{1'b1}};

    typedef struct packed {
        logic           x_neg;
        logic           y_neg;
        logic           z_neg;
        logic           zero;
        logic [L1W-1:0] l1;
        logic [QB-1:0]  nlow;
        logic [RW-1:0]  rem_x;
        logic [RW-1:0]  rem_z;
        logic [QB-1:0]  q_x;
        logic [QB-1:0]  q_z;
    } div_t;

    typedef struct packed {
        logic                 zero;
        logic signed [WW-1:0] w_u;
        logic signed [WW-1:0] w_v;
    } fold_t;

endpackage

[sv/onenc_prep.sv]
// ----------------------------------------------------------------------------
// onenc_prep
// Input stage: sign/magnitude split, l1 norm and divider start values.
// ----------------------------------------------------------------------------
module onenc_prep (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [onenc_pkg::IN_BITS-1:0] in_x,
    input  logic signed [onenc_pkg::IN_BITS-1:0] in_y,
    input  logic signed [onenc_pkg::IN_BITS-1:0] in_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output onenc_pkg::div_t                    out_data
);

    localparam int InW = onenc_pkg::IN_BITS;
    localparam int L1W = onenc_pkg::L1W;
    localparam int RW  = onenc_pkg::RW;
    localparam int QB  = onenc_pkg::QB;

    logic            vld_reg;
    onenc_pkg::div_t data_reg;
    onenc_pkg::div_t data_next;
    logic [InW-1:0]  xm;
    logic [InW-1:0]  ym;
    logic [InW-1:0]  zm;
    logic [L1W-1:0]  l1;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_comb begin
        xm = in_x[InW-1] ? InW'(-in_x) : InW'(in_x);
        ym = in_y[InW-1] ? InW'(-in_y) : InW'(in_y);
        zm = in_z[InW-1] ? InW'(-in_z) : InW'(in_z);
        l1 = L1W'(xm) + L1W'(ym) + L1W'(zm);

        data_next.x_neg = in_x[InW-1];
        data_next.y_neg = in_y[InW-1];
        data_next.z_neg = in_z[InW-1];
        data_next.zero  = (l1 == '0);
        data_next.l1    = l1;
        // low dividend bits come from l1, high part is magnitude plus l1 overflow
        data_next.nlow  = QB'(l1);
        data_next.rem_x = RW'(xm) + RW'(l1 >> QB);
        data_next.rem_z = RW'(zm) + RW'(l1 >> QB);
        data_next.q_x   = '0;
        data_next.q_z   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[sv/onenc_div_stage.sv]
// ----------------------------------------------------------------------------
// onenc_div_stage
// One restoring division step for both lanes: one quotient bit per stage.
// ----------------------------------------------------------------------------
module onenc_div_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  onenc_pkg::div_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output onenc_pkg::div_t out_data
);

    localparam int RW = onenc_pkg::RW;
    localparam int QB = onenc_pkg::QB;

    logic            vld_reg;
    onenc_pkg::div_t data_reg;
    onenc_pkg::div_t data_next;
    logic [RW:0]     dvs;
    logic [RW:0]     t_x;
    logic [RW:0]     t_z;
    logic            ge_x;
    logic            ge_z;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_comb begin
        // divisor is 2 * l1
        dvs  = {1'b0, in_data.l1, 1'b0};
        t_x  = {in_data.rem_x, in_data.nlow[QB-1]};
        t_z  = {in_data.rem_z, in_data.nlow[QB-1]};
        ge_x = (t_x >= dvs);
        ge_z = (t_z >= dvs);

        data_next       = in_data;
        data_next.nlow  = {in_data.nlow[QB-2:0], 1'b0};
        data_next.rem_x = ge_x ? RW'(t_x - dvs) : t_x[RW-1:0];
        data_next.rem_z = ge_z ? RW'(t_z - dvs) : t_z[RW-1:0];
        data_next.q_x   = {in_data.q_x[QB-2:0], ge_x};
        data_next.q_z   = {in_data.q_z[QB-2:0], ge_z};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[sv/onenc_map.sv]
// ----------------------------------------------------------------------------
// onenc_map
// Hemisphere fold and sign, then the *0.5+0.5 map with rounding and
// saturation; the second stage is the output register.
// ----------------------------------------------------------------------------
module onenc_map (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  onenc_pkg::div_t                  in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [onenc_pkg::OUT_BITS-1:0]   out_u,
    output logic [onenc_pkg::OUT_BITS-1:0]   out_v,
    output logic                             out_zero
);

    localparam int WW  = onenc_pkg::WW;
    localparam int OB  = onenc_pkg::OUT_BITS;
    localparam int QF  = onenc_pkg::QF;
    localparam int EW  = WW + OB;

    logic                 fold_vld_reg;
    onenc_pkg::fold_t     fold_reg;
    onenc_pkg::fold_t     fold_next;
    logic                 fold_ready;
    logic signed [WW-1:0] qx;
    logic signed [WW-1:0] qz;
    logic signed [WW-1:0] mu;
    logic signed [WW-1:0] mv;

    logic                 out_vld_reg;
    logic [OB-1:0]        u_reg;
    logic [OB-1:0]        v_reg;
    logic                 zero_reg;
    logic [OB-1:0]        u_next;
    logic [OB-1:0]        v_next;
    logic [WW-1:0]        a_u;
    logic [WW-1:0]        a_v;
    logic [EW-1:0]        e_u;
    logic [EW-1:0]        e_v;
    logic [OB:0]          r_u;
    logic [OB:0]          r_v;
    logic                 out_stage_ready;

    assign out_stage_ready = !out_vld_reg || out_ready;
    assign fold_ready      = !fold_vld_reg || out_stage_ready;
    assign in_ready        = fold_ready;
    assign out_valid       = out_vld_reg;
    assign out_u           = u_reg;
    assign out_v           = v_reg;
    assign out_zero        = zero_reg;

    // fold stage
    always_comb begin
        qx = WW'($signed({1'b0, in_data.q_x}));
        qz = WW'($signed({1'b0, in_data.q_z}));
        if (in_data.y_neg) begin
            mu = $signed(onenc_pkg::ONE_Q) - qz;
            mv = $signed(onenc_pkg::ONE_Q) - qx;
        end else begin
            mu = qx;
            mv = qz;
        end
        fold_next.zero = in_data.zero;
        fold_next.w_u  = in_data.x_neg ? -mu : mu;
        fold_next.w_v  = in_data.z_neg ? -mv : mv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_vld_reg <= 1'b0;
        end else if (fold_ready) begin
            fold_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fold_ready && in_valid) begin
            fold_reg <= fold_next;
        end
    end

    // map stage
    always_comb begin
        a_u = WW'(fold_reg.w_u) + onenc_pkg::ONE_Q;
        a_v = WW'(fold_reg.w_v) + onenc_pkg::ONE_Q;
        e_u = {a_u, {OB{1'b0}}} + (EW'(1) << QF);
        e_v = {a_v, {OB{1'b0}}} + (EW'(1) << QF);
        r_u = e_u[EW-1:QF+1];
        r_v = e_v[EW-1:QF+1];
        if (fold_reg.zero) begin
            u_next = onenc_pkg::OUT_HALF;
            v_next = onenc_pkg::OUT_HALF;
        end else begin
            u_next = r_u[OB] ? onenc_pkg::OUT_MAX : r_u[OB-1:0];
            v_next = r_v[OB] ? onenc_pkg::OUT_MAX : r_v[OB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_stage_ready) begin
            out_vld_reg <= fold_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_stage_ready && fold_vld_reg) begin
            u_reg    <= u_next;
            v_reg    <= v_next;
            zero_reg <= fold_reg.zero;
        end
    end

endmodule

[sv/octahedral_normal_encode_core.sv]
// ----------------------------------------------------------------------------
// octahedral_normal_encode_core
// Octahedral encoding of a signed fixed-point normal into two unsigned
// coordinates, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one normal per cycle unless stalled and returns its (u, v) octahedral
// coordinates: one input stage forms magnitudes and the l1 norm, 17 divider
// stages each produce one quotient bit for x and z side by side, and two
// stages fold the lower hemisphere and map to unsigned fixed point. Every
// stage holds its item while the next one is full, so back-pressure on the
// result channel stops only the stages behind the waiting item. An all-zero
// vector returns u = v = half scale with the zero_vector flag in tuser.
// ----------------------------------------------------------------------------
module octahedral_normal_encode_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // norm_x, norm_y, norm_z
    input  logic [onenc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // enc_u, enc_v
    output logic [onenc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // zero_vector
    output logic                                 m_axis_tuser
);

    localparam int InW = onenc_pkg::IN_BITS;
    localparam int QB  = onenc_pkg::QB;
    localparam int OB  = onenc_pkg::OUT_BITS;

    onenc_pkg::div_t stage_data  [QB+1];
    logic            stage_valid [QB+1];
    logic            stage_ready [QB+1];
    logic [OB-1:0]   enc_u;
    logic [OB-1:0]   enc_v;

    onenc_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_x      ($signed(s_axis_tdata[InW-1:0])),
        .in_y      ($signed(s_axis_tdata[2*InW-1:InW])),
        .in_z      ($signed(s_axis_tdata[3*InW-1:2*InW])),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_data  (stage_data[0])
    );

    for (genvar i = 0; i < QB; i++) begin : g_div
        onenc_div_stage u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    onenc_map u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stage_valid[QB]),
        .in_ready  (stage_ready[QB]),
        .in_data   (stage_data[QB]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_u     (enc_u),
        .out_v     (enc_v),
        .out_zero  (m_axis_tuser)
    );

    assign m_axis_tdata = onenc_pkg::M_TDATA_W'({enc_v, enc_u});

endmodule

[sv/onenc_checker.sv]
// ----------------------------------------------------------------------------
// onenc_checker
// Port-level checks of the octahedral normal encoder, bound to the top level.
// ----------------------------------------------------------------------------
module onenc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [onenc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);

    localparam int OB = onenc_pkg::OUT_BITS;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // zero vector maps to the center
    a_zero_center: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[OB-1:0] == onenc_pkg::OUT_HALF &&
            m_axis_tdata[2*OB-1:OB] == onenc_pkg::OUT_HALF)
        else $error("zero vector not at center");

    // input side blocks only behind a waiting result
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // reset empties the pipeline
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // no item appears when nothing ever entered since reset
    a_start_empty: assert property (@(posedge aclk)
        !aresetn ##1 !s_axis_tvalid |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind octahedral_normal_encode_core onenc_checker u_onenc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
